// File: hdl/mf_pkg.sv
// Shared types, constants and compare helpers for the 3x3 median filter.
// No dependencies; every other file but mf_ram imports this package.
package mf_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = 11;
    localparam int ROW_W     = 16;
    localparam int PIX_W     = 8;
    localparam int OCOL_W    = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // output queue, power of two deep
    localparam int QDEPTH = 8;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;
    localparam int QMAX_PUSH = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [WID_W-1:0] RST_FRAME_WIDTH  = WID_W'(640);
    localparam logic [ROW_W-1:0] RST_FRAME_HEIGHT = ROW_W'(480);

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [COL_W-1:0] t_col;
    typedef logic [ROW_W-1:0] t_row;

    typedef struct packed {
        t_pix lo;
        t_pix mid;
        t_pix hi;
    } t_column;

    typedef struct packed {
        t_pix lo_max;
        t_pix mid_med;
        t_pix hi_min;
        t_pix center;
        t_pix p1;
        t_pix pix;
        t_row row;
        t_col col;
        logic has1;
        logic interior;
        logic has2;
        logic has3;
    } t_stage2;

    typedef struct packed {
        t_pix pix;
        t_row row;
        t_col col;
        logic last;
    } t_result;

    function automatic t_pix max2(input t_pix a, input t_pix b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_pix min2(input t_pix a, input t_pix b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_pix max3(input t_pix a, input t_pix b, input t_pix c);
        return max2(max2(a, b), c);
    endfunction

    function automatic t_pix min3(input t_pix a, input t_pix b, input t_pix c);
        return min2(min2(a, b), c);
    endfunction

    function automatic t_pix med3(input t_pix a, input t_pix b, input t_pix c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic t_column sort3(input t_pix a, input t_pix b, input t_pix c);
        t_column s;
        s.lo  = min3(a, b, c);
        s.mid = med3(a, b, c);
        s.hi  = max3(a, b, c);
        return s;
    endfunction

endpackage

// File: hdl/mf_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// Read-during-write to the same address returns the old data. No dependencies.
module mf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/mf_line_window.sv
// Front end: row/column counters, line store, sorted-column window and the
// first two pipeline registers. Depends on mf_pkg and mf_ram.
module mf_line_window
    import mf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_pix             i_pixel,
    input  logic [WID_W-1:0] i_width,
    input  t_row             i_height,
    output t_stage2          o_s2,
    output logic             o_s2_valid,
    input  logic             i_s2_ready
);

    localparam int WE_W = COL_W + 1;

    // counters
    t_col r_col, n_col;
    t_row r_row, n_row;

    // stage 1
    logic r_s1_valid;
    t_pix r_s1_pix;
    t_row r_s1_row;
    t_col r_s1_col;
    logic r_s1_has1, r_s1_interior, r_s1_has2, r_s1_has3;
    logic r_s1_fwd;
    t_pix r_s1_fwd_p1, r_s1_fwd_p2;

    // window: two sorted columns and the raw center pixel
    t_column r_win_a, r_win_b;
    t_pix    r_center;

    // stage 2
    logic    r_s2_valid;
    t_stage2 r_s2;

    logic [WE_W-1:0]  w_eff;
    t_row             h_eff;
    t_col             c0;
    t_row             r0;
    logic [WE_W-1:0]  c0_inc;
    logic [ROW_W:0]   r0_inc;
    logic             accept, s1_adv, s2_adv;
    logic             has1, interior, has2, has3;
    logic [2*PIX_W-1:0] ram_rdata;
    t_pix             p1_eff, p2_eff;
    t_column          new_col;

    assign s2_adv     = !r_s2_valid || i_s2_ready;
    assign s1_adv     = r_s1_valid && s2_adv;
    assign o_in_ready = !r_s1_valid || s2_adv;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        if (i_width == '0) begin
            w_eff = WE_W'(1);
        end else if (32'(i_width) > 32'(MAX_WIDTH)) begin
            w_eff = WE_W'(MAX_WIDTH);
        end else begin
            w_eff = WE_W'(i_width);
        end
        h_eff = (i_height == '0) ? ROW_W'(1) : i_height;
        c0 = (WE_W'(r_col) >= w_eff) ? '0 : r_col;
        r0 = (r_row >= h_eff) ? '0 : r_row;
        c0_inc = WE_W'(c0) + WE_W'(1);
        r0_inc = (ROW_W+1)'(r0) + (ROW_W+1)'(1);

        has1     = (r0 != '0) && (c0 != '0);
        interior = (r0 >= ROW_W'(2)) && (c0 >= COL_W'(2));
        has2     = (r0 != '0) && (c0_inc == w_eff);
        has3     = (r0_inc == (ROW_W+1)'(h_eff));

        if (c0_inc >= w_eff) begin
            n_col = '0;
            n_row = (r0_inc >= (ROW_W+1)'(h_eff)) ? '0 : r0_inc[ROW_W-1:0];
        end else begin
            n_col = c0_inc[COL_W-1:0];
            n_row = r0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line store: upper byte is row r-2, lower byte is row r-1
    mf_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata ({p1_eff, r_s1_pix}),
        .i_re    (accept),
        .i_raddr (c0),
        .o_rdata (ram_rdata)
    );

    assign p1_eff  = r_s1_fwd ? r_s1_fwd_p1 : ram_rdata[PIX_W-1:0];
    assign p2_eff  = r_s1_fwd ? r_s1_fwd_p2 : ram_rdata[2*PIX_W-1:PIX_W];
    assign new_col = sort3(p2_eff, p1_eff, r_s1_pix);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    // same address written by the beat leaving stage 1: bypass the RAM
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix      <= i_pixel;
            r_s1_row      <= r0;
            r_s1_col      <= c0;
            r_s1_has1     <= has1;
            r_s1_interior <= interior;
            r_s1_has2     <= has2;
            r_s1_has3     <= has3;
            r_s1_fwd      <= r_s1_valid && (c0 == r_s1_col);
            r_s1_fwd_p1   <= r_s1_pix;
            r_s1_fwd_p2   <= p1_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_win_b         <= r_win_a;
            r_win_a         <= new_col;
            r_center        <= p1_eff;
            r_s2.lo_max     <= max3(r_win_b.lo, r_win_a.lo, new_col.lo);
            r_s2.mid_med    <= med3(r_win_b.mid, r_win_a.mid, new_col.mid);
            r_s2.hi_min     <= min3(r_win_b.hi, r_win_a.hi, new_col.hi);
            r_s2.center     <= r_center;
            r_s2.p1         <= p1_eff;
            r_s2.pix        <= r_s1_pix;
            r_s2.row        <= r_s1_row;
            r_s2.col        <= r_s1_col;
            r_s2.has1       <= r_s1_has1;
            r_s2.interior   <= r_s1_interior;
            r_s2.has2       <= r_s1_has2;
            r_s2.has3       <= r_s1_has3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    assign o_s2       = r_s2;
    assign o_s2_valid = r_s2_valid;

endmodule

// File: hdl/mf_result_queue.sv
// Final median select, result formation and the output queue that turns up
// to three results per pixel into single output beats. Depends on mf_pkg.
module mf_result_queue
    import mf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_stage2 i_s2,
    input  logic    i_s2_valid,
    output logic    o_s2_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_result
);

    t_result r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;

    t_result           res [QMAX_PUSH];
    logic              res_en [QMAX_PUSH];
    logic [QPTR_W-1:0] res_idx [QMAX_PUSH];
    logic [1:0]        push_n;
    logic              push, pop;
    t_pix              med;

    assign o_s2_ready  = (r_count <= QCNT_W'(QDEPTH - QMAX_PUSH));
    assign push        = i_s2_valid && o_s2_ready;
    assign o_out_valid = (r_count != '0);
    assign pop         = o_out_valid && i_out_ready;
    assign o_result    = r_mem[r_rd];

    always_comb begin
        med = med3(i_s2.lo_max, i_s2.mid_med, i_s2.hi_min);

        res[0].pix  = i_s2.interior ? med : i_s2.center;
        res[0].row  = i_s2.row - ROW_W'(1);
        res[0].col  = i_s2.col - COL_W'(1);
        res[0].last = !i_s2.has2 && !i_s2.has3;

        res[1].pix  = i_s2.p1;
        res[1].row  = i_s2.row - ROW_W'(1);
        res[1].col  = i_s2.col;
        res[1].last = !i_s2.has3;

        res[2].pix  = i_s2.pix;
        res[2].row  = i_s2.row;
        res[2].col  = i_s2.col;
        res[2].last = 1'b1;

        res_en[0] = i_s2.has1;
        res_en[1] = i_s2.has2;
        res_en[2] = i_s2.has3;

        res_idx[0] = r_wr;
        res_idx[1] = r_wr + QPTR_W'(i_s2.has1);
        res_idx[2] = r_wr + QPTR_W'(i_s2.has1) + QPTR_W'(i_s2.has2);

        push_n = 2'(i_s2.has1) + 2'(i_s2.has2) + 2'(i_s2.has3);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QMAX_PUSH; k++) begin
            if (push && res_en[k]) begin
                r_mem[res_idx[k]] <= res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + QPTR_W'(push_n);
            end
            if (pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_count <= r_count + (push ? QCNT_W'(push_n) : '0) - QCNT_W'(pop);
        end
    end

endmodule

// File: hdl/median_filter_3x3_core.sv
// Top level of the streaming 3x3 median filter: configuration registers and
// the two datapath parts. Depends on mf_pkg, mf_line_window, mf_result_queue.
//
// Usage:
//   Pixels of a frame enter in raster order on the input channel, one beat
//   per pixel. Each result beat carries the filtered pixel with its row and
//   column; o_last_of_run marks the final result caused by one input pixel.
//   Interior pixels are the median of their 3x3 neighborhood, border pixels
//   pass through unchanged. Results lag the input by at most a row and a column.
//   Frame width (index 0) and height (index 1) are written on the config
//   channel, which is always ready; write them only while the block is idle.
//   Throughput: one pixel per cycle, set by the dual-port line store read
//   and the one-result-per-cycle output queue; a pixel may cause up to three
//   results, so the output side sets the pace when it is behind.
//   The first result of a pixel passes the input register, the window stage
//   and the queue write before it is presented; its further results follow
//   one per cycle while the receiver is ready.
//   Reset clears counters, pipeline and queue; width and height go to 640
//   and 480. The line store needs no clearing. When the receiver stalls the
//   eight-entry queue fills and o_in_ready drops; nothing is lost.
module median_filter_3x3_core
    import mf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [PIX_W-1:0]     i_pixel_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [PIX_W-1:0]     o_pixel_out,
    output logic [ROW_W-1:0]     o_out_row,
    output logic [OCOL_W-1:0]    o_out_col,
    output logic                 o_last_of_run,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    logic [WID_W-1:0] r_frame_width;
    t_row             r_frame_height;
    t_stage2          s2;
    logic             s2_valid, s2_ready;
    t_result          result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[WID_W-1:0];
                end
                CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[ROW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    mf_line_window u_line_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_pixel    (i_pixel_in),
        .i_width    (r_frame_width),
        .i_height   (r_frame_height),
        .o_s2       (s2),
        .o_s2_valid (s2_valid),
        .i_s2_ready (s2_ready)
    );

    mf_result_queue u_result_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s2        (s2),
        .i_s2_valid  (s2_valid),
        .o_s2_ready  (s2_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_pixel_out   = result.pix;
    assign o_out_row     = result.row;
    assign o_out_col     = OCOL_W'(result.col);
    assign o_last_of_run = result.last;

endmodule

// File: hdl/mf_checker.sv
// Port-level checks for median_filter_3x3_core, attached by bind.
// Depends on mf_pkg and the top level's port list.
module mf_checker
    import mf_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [PIX_W-1:0]     o_pixel_out,
    input logic [ROW_W-1:0]     o_out_row,
    input logic [OCOL_W-1:0]    o_out_col,
    input logic                 o_last_of_run
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pixel_out)
            && $stable(o_out_row) && $stable(o_out_col) && $stable(o_last_of_run))
        else $error("result beat changed while stalled");

    // input back-pressure only comes from a backed-up queue
    a_ready_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready right after reset");

endmodule

bind median_filter_3x3_core mf_checker u_mf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_pixel_out   (o_pixel_out),
    .o_out_row     (o_out_row),
    .o_out_col     (o_out_col),
    .o_last_of_run (o_last_of_run)
);

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for median_filter_3x3_core: random pixel frames, a line-store
// predictor of the filter, and field-by-field checks of every result beat.
// Depends on mf_pkg and the RTL of the block only.
module testbench;
    import mf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);
    localparam int IDLE_LIMIT  = 2000;
    localparam int SETTLE_CYC  = 8;
    localparam int RAND_PIXELS = 190;
    localparam int WIDE_PIXELS = 16;

    typedef struct packed {
        logic [PIX_W-1:0]  pix;
        logic [ROW_W-1:0]  row;
        logic [OCOL_W-1:0] col;
        logic              last;
    } t_filt_beat;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] data;
    } t_reg_write;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic [PIX_W-1:0]     pixel_in = '0;
    logic                 out_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    wire                  in_ready;
    wire                  out_valid;
    wire [PIX_W-1:0]      pixel_out;
    wire [ROW_W-1:0]      out_row;
    wire [OCOL_W-1:0]     out_col;
    wire                  last_of_run;
    wire                  cfg_ready;

    median_filter_3x3_core i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_pixel_in   (pixel_in),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_pixel_out  (pixel_out),
        .o_out_row    (out_row),
        .o_out_col    (out_col),
        .o_last_of_run(last_of_run),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [PIX_W-1:0] pix_pend[$];
    t_reg_write       cfg_pend[$];
    t_filt_beat       beat_q[$];
    int               err_count = 0;

    // filter model state
    logic [PIX_W-1:0] up1_line [MAX_WIDTH];
    logic [PIX_W-1:0] up2_line [MAX_WIDTH];
    logic [PIX_W-1:0] win_px [6];
    int               cur_col = 0;
    int               cur_row = 0;
    logic [WID_W-1:0] reg_width = RST_FRAME_WIDTH;
    logic [ROW_W-1:0] reg_height = RST_FRAME_HEIGHT;

    task automatic flag_error(input string what);
        if (err_count < 50) $display("mismatch: %s", what);
        err_count++;
    endtask

    function automatic int eff_width();
        int w;
        w = reg_width;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = reg_height;
        if (h == 0) h = 1;
        return h;
    endfunction

    function automatic logic [PIX_W-1:0] median_of_nine(input logic [9*PIX_W-1:0] nb);
        int lt, le;
        logic [PIX_W-1:0] a, b;
        for (int i = 0; i < 9; i++) begin
            a = nb[i*PIX_W +: PIX_W];
            lt = 0;
            le = 0;
            for (int j = 0; j < 9; j++) begin
                b = nb[j*PIX_W +: PIX_W];
                if (b < a) lt++;
                if (b <= a) le++;
            end
            if (lt <= 4 && le >= 5) return a;
        end
        return '0;
    endfunction

    function automatic t_filt_beat mk_beat(input logic [PIX_W-1:0] v, input int r, input int c);
        t_filt_beat b;
        b.pix  = v;
        b.row  = ROW_W'(r);
        b.col  = OCOL_W'(c);
        b.last = 1'b0;
        return b;
    endfunction

    task automatic predict_pixel(input logic [PIX_W-1:0] pix);
        int w, h, r, c, n;
        logic [PIX_W-1:0] p1, p2, v;
        t_filt_beat outs [3];
        w = eff_width();
        h = eff_height();
        if (cur_col >= w) cur_col = 0;
        if (cur_row >= h) cur_row = 0;
        r = cur_row;
        c = cur_col;
        n = 0;
        p1 = up1_line[c];
        p2 = up2_line[c];
        if (r >= 1 && c >= 1) begin
            v = win_px[4];
            if (r >= 2 && r + 1 <= h && c >= 2 && c + 1 <= w)
                v = median_of_nine({win_px[0], win_px[1], win_px[2], win_px[3],
                                    win_px[4], win_px[5], p2, p1, pix});
            outs[n] = mk_beat(v, r - 1, c - 1);
            n++;
        end
        if (r >= 1 && c + 1 == w) begin
            outs[n] = mk_beat(p1, r - 1, c);
            n++;
        end
        if (r + 1 == h) begin
            outs[n] = mk_beat(pix, r, c);
            n++;
        end
        if (n > 0) outs[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) beat_q = {beat_q, outs[i]};

        up2_line[c] = p1;
        up1_line[c] = pix;
        win_px[0] = win_px[3];
        win_px[1] = win_px[4];
        win_px[2] = win_px[5];
        win_px[3] = p2;
        win_px[4] = p1;
        win_px[5] = pix;
        if (c + 1 >= w) begin
            cur_col = 0;
            cur_row = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            cur_col = c + 1;
        end
    endtask

    // pixel driver, bursts with gaps
    int burst_left = 8;
    int gap_left = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            pixel_in <= '0;
            burst_left <= 8;
            gap_left <= 0;
            cur_col = 0;
            cur_row = 0;
        end else begin
            if (in_valid && in_ready) predict_pixel(pixel_in);
            if (!in_valid || in_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pix_pend.size() != 0) begin
                    in_valid <= 1'b1;
                    pixel_in <= pix_pend.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
                                                                  : $urandom_range(1, 16);
                        gap_left <= $urandom_range(0, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            cfg_valid <= 1'b0;
            cfg_index <= '0;
            cfg_data <= '0;
            reg_width = RST_FRAME_WIDTH;
            reg_height = RST_FRAME_HEIGHT;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_FRAME_WIDTH) reg_width = cfg_data[WID_W-1:0];
                else if (cfg_index == CFG_FRAME_HEIGHT) reg_height = cfg_data[ROW_W-1:0];
            end
            if (!cfg_valid || cfg_ready) begin
                if (cfg_pend.size() != 0) begin
                    cfg_valid <= 1'b1;
                    {cfg_index, cfg_data} <= cfg_pend.pop_front();
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with its own stall pattern
    int stall_mode = 0;
    int mode_left = 0;
    int hold_left = 0;

    always @(posedge clk) begin
        t_filt_beat got, want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_mode <= 0;
            mode_left <= 0;
            hold_left <= 0;
        end else begin
            if (out_valid && out_ready) begin
                got = {pixel_out, out_row, out_col, last_of_run};
                if (beat_q.size() == 0) begin
                    flag_error($sformatf("unexpected beat pix=%0d row=%0d col=%0d last=%0b",
                                         got.pix, got.row, got.col, got.last));
                end else begin
                    want = beat_q.pop_front();
                    if (got !== want)
                        flag_error({$sformatf("got pix=%0d row=%0d col=%0d last=%0b",
                                              got.pix, got.row, got.col, got.last),
                                    $sformatf(", want pix=%0d row=%0d col=%0d last=%0b",
                                              want.pix, want.row, want.col, want.last)});
                end
            end
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(64, 400);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                default: begin
                    if (hold_left != 0) begin
                        hold_left <= hold_left - 1;
                        out_ready <= 1'b0;
                    end else if ($urandom_range(0, 15) == 0) begin
                        hold_left <= $urandom_range(1, 24);
                        out_ready <= 1'b0;
                    end else begin
                        out_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    wire any_beat = (in_valid && in_ready) || (out_valid && out_ready) ||
                    (cfg_valid && cfg_ready);
    int idle_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n || any_beat) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic logic [PIX_W-1:0] pick_pixel();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k == 0) return '0;
        if (k == 1) return '1;
        if (k < 4) return PIX_W'($urandom_range(126, 130));
        return PIX_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [CFG_DAT_W-1:0] pick_width_word();
        int unsigned k, w;
        k = $urandom_range(0, 9);
        if (k == 0) w = 0;
        else if (k == 1) w = $urandom_range(9, 24);
        else w = $urandom_range(1, 8);
        return (CFG_DAT_W'($urandom_range(0, 31)) << WID_W) | CFG_DAT_W'(w);
    endfunction

    function automatic logic [CFG_DAT_W-1:0] pick_height_word();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k == 0) return '0;
        if (k == 1) return CFG_DAT_W'($urandom_range(9, 65535));
        return CFG_DAT_W'($urandom_range(1, 7));
    endfunction

    task automatic queue_pixel(input logic [PIX_W-1:0] v);
        pix_pend = {pix_pend, v};
    endtask

    task automatic queue_pixels(input int n);
        for (int i = 0; i < n; i++) queue_pixel(pick_pixel());
    endtask

    task automatic settle();
        @(negedge clk);
        while (pix_pend.size() != 0 || in_valid || beat_q.size() != 0 ||
               cfg_pend.size() != 0 || cfg_valid)
            @(negedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        t_reg_write wr;
        wr.idx = idx;
        wr.data = data;
        @(negedge clk);
        cfg_pend = {cfg_pend, wr};
        @(negedge clk);
        while (cfg_pend.size() != 0 || cfg_valid) @(negedge clk);
    endtask

    initial begin
        int n, n2, fw, fh, rand_px;
        logic trunc;
        rand_px = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry: a few pixels of row 0, nothing comes out
        queue_pixel(8'h00);
        queue_pixel(8'hFF);
        queue_pixel(8'h55);
        settle();

        // 3x3 frame; column counter at 3 wraps to 0
        write_reg(CFG_FRAME_WIDTH, 16'd3);
        write_reg(CFG_FRAME_HEIGHT, 16'd3);
        queue_pixel(8'hFF); queue_pixel(8'h00); queue_pixel(8'hFF);
        queue_pixel(8'h00); queue_pixel(8'h80); queue_pixel(8'hFF);
        queue_pixel(8'hAA); queue_pixel(8'h55); queue_pixel(8'h01);
        settle();

        // spare indices are ignored, height zero acts as one
        write_reg(CFG_SPARE_A, 16'hFFFF);
        write_reg(CFG_SPARE_B, 16'h0000);
        write_reg(CFG_FRAME_HEIGHT, 16'd0);
        queue_pixels(3);
        settle();

        // width zero acts as one
        write_reg(CFG_FRAME_WIDTH, 16'd0);
        queue_pixels(2);
        settle();

        // tallest frame, cut short by a smaller height mid-frame
        write_reg(CFG_FRAME_WIDTH, 16'hF802);
        write_reg(CFG_FRAME_HEIGHT, 16'hFFFF);
        queue_pixels(5);
        settle();
        write_reg(CFG_FRAME_HEIGHT, 16'd2);
        queue_pixels(3);

        while (rand_px < RAND_PIXELS) begin
            settle();
            if (rand_px == 0 || $urandom_range(0, 4) != 0)
                write_reg(CFG_FRAME_WIDTH, pick_width_word());
            if (rand_px == 0 || $urandom_range(0, 4) != 0)
                write_reg(CFG_FRAME_HEIGHT, pick_height_word());
            if ($urandom_range(0, 15) == 0)
                write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_A : CFG_SPARE_B,
                          CFG_DAT_W'($urandom));
            fw = eff_width();
            fh = eff_height();
            trunc = (fh > 8) || (fh >= 3 && $urandom_range(0, 3) == 0);
            if (trunc) begin
                n = $urandom_range(fw, fw * ((fh > 8) ? 4 : fh) - 1);
                queue_pixels(n);
                settle();
                write_reg(CFG_FRAME_HEIGHT, CFG_DAT_W'($urandom_range(1, cur_row)));
                n2 = eff_height() * fw - cur_col;
                queue_pixels(n2);
                rand_px += n + n2;
            end else begin
                n = fw * fh * $urandom_range(1, 2);
                queue_pixels(n);
                rand_px += n;
            end
        end

        // widest setting: width field 2047 clamps to 1024, single-row frame
        settle();
        write_reg(CFG_FRAME_WIDTH, 16'hFFFF);
        write_reg(CFG_FRAME_HEIGHT, 16'd1);
        queue_pixels(WIDE_PIXELS);

        settle();
        repeat (20) @(posedge clk);
        if (beat_q.size() != 0)
            flag_error($sformatf("%0d expected beats never arrived", beat_q.size()));
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
